>>> hdl/msrs_pkg.sv
// msrs_pkg: shared types and constants for the magnetometer set/reset sequencer
// no dependencies; used by the interfaces, the axis datapath and the top level

package msrs_pkg;

	// fixed field widths
	localparam int RAW_W   = 20;
	localparam int FIELD_W = 20;
	localparam int LIMIT_W = 16;
	localparam int CTL_W   = 8;

	// default axis count width (valid range 16 to 20)
	localparam int COUNT_BITS_DEF = 20;

	// plain sample limit after reset
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd50;

	// output scaling: field = floor(-d * SCALE_NUM / 2^SCALE_SHIFT)
	localparam int SCALE_NUM   = 1000;
	localparam int SCALE_SHIFT = 11;
	localparam int FIELD_MAX   = 524287;

	// control register codes
	localparam logic [CTL_W-1:0] CTL_NONE  = 8'h00;
	localparam logic [CTL_W-1:0] CTL_TMM   = 8'h01;
	localparam logic [CTL_W-1:0] CTL_SET   = 8'h08;
	localparam logic [CTL_W-1:0] CTL_RESET = 8'h10;

	// sequencer phases
	typedef enum logic [2:0] {
		PH_SET      = 3'd0,
		PH_SET_MEAS = 3'd1,
		PH_SET_WAIT = 3'd2,
		PH_RST_MEAS = 3'd3,
		PH_RST_WAIT = 3'd4,
		PH_MEASURE  = 3'd5
	} phase_t;

	// per-axis control from the sequencer, already qualified by the word being taken
	typedef struct packed {
		logic latch_set;  // store the reading taken after SET
		logic sr_pair;    // set/reset pair sample: emit half difference, store offset
	} axis_ctl_t;

endpackage

>>> hdl/msrs_in_if.sv
// msrs_in_if: input channel, one word per tick with bus access outcomes and axis counts
// depends on msrs_pkg for field widths

interface msrs_in_if;
	logic                           valid;
	logic                           ready;
	logic                           write_ok;
	logic                           status_read_ok;
	logic                           measure_done;
	logic                           data_read_ok;
	logic [msrs_pkg::RAW_W-1:0]     raw_x;
	logic [msrs_pkg::RAW_W-1:0]     raw_y;
	logic [msrs_pkg::RAW_W-1:0]     raw_z;

	modport source (
		output valid, write_ok, status_read_ok, measure_done, data_read_ok,
		output raw_x, raw_y, raw_z,
		input  ready
	);
	modport sink (
		input  valid, write_ok, status_read_ok, measure_done, data_read_ok,
		input  raw_x, raw_y, raw_z,
		output ready
	);
endinterface

>>> hdl/msrs_out_if.sv
// msrs_out_if: result channel, bus requests for the tick and the corrected field sample
// depends on msrs_pkg for field widths

interface msrs_out_if;
	logic                                valid;
	logic                                ready;
	logic                                control_write;
	logic [msrs_pkg::CTL_W-1:0]          control_value;
	logic                                data_read;
	logic                                sample_valid;
	logic signed [msrs_pkg::FIELD_W-1:0] field_x;
	logic signed [msrs_pkg::FIELD_W-1:0] field_y;
	logic signed [msrs_pkg::FIELD_W-1:0] field_z;

	modport source (
		output valid, control_write, control_value, data_read, sample_valid,
		output field_x, field_y, field_z,
		input  ready
	);
	modport sink (
		input  valid, control_write, control_value, data_read, sample_valid,
		input  field_x, field_y, field_z,
		output ready
	);
endinterface

>>> hdl/msrs_axis.sv
// msrs_axis: one axis of offset cancellation, holds the set reading and the bridge offset
// depends on msrs_pkg (axis_ctl_t, scaling constants)

module msrs_axis #(
	parameter int COUNT_BITS = msrs_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  msrs_pkg::axis_ctl_t                 ctl,
	input  logic [COUNT_BITS-1:0]               raw,
	output logic signed [msrs_pkg::FIELD_W-1:0] field
);

	localparam int OW = COUNT_BITS + 1;                 // offset sum width
	localparam int DW = COUNT_BITS + 3;                 // difference width
	localparam int PW = DW + 10;                        // product width (1000 < 2^10)
	localparam int QW = PW - msrs_pkg::SCALE_SHIFT;     // shifted width
	localparam int QX = QW + msrs_pkg::FIELD_W;         // compare width
	localparam logic signed [PW-1:0] SCALE = PW'(msrs_pkg::SCALE_NUM);
	localparam logic signed [QX-1:0] SAT_HI = QX'(msrs_pkg::FIELD_MAX);
	localparam logic signed [QX-1:0] SAT_LO = -SAT_HI - QX'(1);

	logic [COUNT_BITS-1:0]        set_reading_q;
	logic signed [OW-1:0]         offset_sum_q;
	logic signed [COUNT_BITS-1:0] c_new;
	logic signed [COUNT_BITS-1:0] c_set;
	logic signed [DW-1:0]         d;
	logic signed [PW-1:0]         p;
	logic signed [QW-1:0]         q;
	logic signed [QX-1:0]         qx;

	// center counts: subtracting half scale flips the top bit
	assign c_new = $signed({~raw[COUNT_BITS-1], raw[COUNT_BITS-2:0]});
	assign c_set = $signed({~set_reading_q[COUNT_BITS-1], set_reading_q[COUNT_BITS-2:0]});

	// difference: reset minus set for the pair, twice the reading minus offset otherwise
	always_comb begin
		if (ctl.sr_pair) begin
			d = DW'(c_new) - DW'(c_set);
		end else begin
			d = (DW'(c_new) <<< 1) - DW'(offset_sum_q);
		end
	end

	// scale by -1000/2048 with floor, then saturate to the field range
	assign p  = -(PW'(d) * SCALE);
	assign q  = $signed(p[PW-1:msrs_pkg::SCALE_SHIFT]);
	assign qx = QX'(q);

	always_comb begin
		if (qx > SAT_HI) begin
			field = SAT_HI[msrs_pkg::FIELD_W-1:0];
		end else if (qx < SAT_LO) begin
			field = SAT_LO[msrs_pkg::FIELD_W-1:0];
		end else begin
			field = qx[msrs_pkg::FIELD_W-1:0];
		end
	end

	// set reading, no reset needed: always written before the pair is formed
	always_ff @(posedge clk) begin
		if (ctl.latch_set) begin
			set_reading_q <= raw;
		end
	end

	// bridge offset: sum of the centered set and reset readings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_sum_q <= '0;
		end else if (ctl.sr_pair) begin
			offset_sum_q <= OW'(c_set) + OW'(c_new);
		end
	end

endmodule

>>> hdl/magnetometer_set_reset_sequencer.sv
// magnetometer_set_reset_sequencer: set/reset offset-cancelling measurement sequencer
// depends on msrs_pkg, msrs_in_if, msrs_out_if and msrs_axis
//
//  channel   direction  handshake        word
//  in_ch     in         valid/ready      bus outcomes of the tick, raw x/y/z counts
//  out_ch    out        valid/ready      bus requests for the tick, corrected field x/y/z
//  cfg       in         cfg_we only      plain sample limit, 16 bits
//
// One word per cycle sustained while out_ch is ready; a word taken sits in the input
// register, moves on to the result register once that register is empty or being
// drained, and is offered from there (sequencer and axis scaling run in between).
// Reset puts the sequencer in the set phase with offsets and count cleared, limit 50.
// A stalled result holds; the input register keeps taking words while the result
// register drains, and stalls only when both are full.

module magnetometer_set_reset_sequencer #(
	parameter int COUNT_BITS = msrs_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	msrs_in_if.sink                       in_ch,
	msrs_out_if.source                    out_ch,
	input  logic                          cfg_we,
	input  logic [msrs_pkg::LIMIT_W-1:0]  cfg_data
);

	// input register
	logic                  v_s1;
	logic                  wok_s1;
	logic                  sok_s1;
	logic                  done_s1;
	logic                  dok_s1;
	logic [COUNT_BITS-1:0] raw_x_s1;
	logic [COUNT_BITS-1:0] raw_y_s1;
	logic [COUNT_BITS-1:0] raw_z_s1;

	// result register
	logic                                out_v_q;
	logic                                cw_q;
	logic [msrs_pkg::CTL_W-1:0]          cv_q;
	logic                                dr_q;
	logic                                sv_q;
	logic signed [msrs_pkg::FIELD_W-1:0] fx_q;
	logic signed [msrs_pkg::FIELD_W-1:0] fy_q;
	logic signed [msrs_pkg::FIELD_W-1:0] fz_q;

	// sequencer state and config
	msrs_pkg::phase_t             ph_q;
	msrs_pkg::phase_t             ph_d;
	logic [msrs_pkg::LIMIT_W-1:0] cnt_q;
	logic [msrs_pkg::LIMIT_W-1:0] cnt_d;
	logic [msrs_pkg::LIMIT_W-1:0] limit_q;

	// decoded outputs for the word in the input register
	logic                       cw;
	logic [msrs_pkg::CTL_W-1:0] cv;
	logic                       dr;
	logic                       sv;
	logic                       latch_set;
	logic                       sr_pair;
	logic                       read_fail;
	logic                       got;

	logic                                advance;
	logic                                fire;
	msrs_pkg::axis_ctl_t                 axis_ctl;
	logic signed [msrs_pkg::FIELD_W-1:0] fx;
	logic signed [msrs_pkg::FIELD_W-1:0] fy;
	logic signed [msrs_pkg::FIELD_W-1:0] fz;

	// handshake
	assign advance     = !out_v_q || out_ch.ready;
	assign fire        = v_s1 && advance;
	assign in_ch.ready = !v_s1 || advance;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= msrs_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			wok_s1   <= in_ch.write_ok;
			sok_s1   <= in_ch.status_read_ok;
			done_s1  <= in_ch.measure_done;
			dok_s1   <= in_ch.data_read_ok;
			raw_x_s1 <= in_ch.raw_x[COUNT_BITS-1:0];
			raw_y_s1 <= in_ch.raw_y[COUNT_BITS-1:0];
			raw_z_s1 <= in_ch.raw_z[COUNT_BITS-1:0];
		end
	end

	// read outcome of the wait and measure phases
	assign read_fail = !sok_s1 || (done_s1 && !dok_s1);
	assign got       = sok_s1 && done_s1 && dok_s1;

	// sequencer next state and outputs
	always_comb begin
		ph_d      = ph_q;
		cnt_d     = cnt_q;
		cw        = 1'b0;
		cv        = msrs_pkg::CTL_NONE;
		dr        = 1'b0;
		sv        = 1'b0;
		latch_set = 1'b0;
		sr_pair   = 1'b0;
		case (ph_q)
			msrs_pkg::PH_SET_MEAS: begin
				cw = 1'b1;
				cv = msrs_pkg::CTL_TMM;
				if (wok_s1) ph_d = msrs_pkg::PH_SET_WAIT;
			end
			msrs_pkg::PH_SET_WAIT: begin
				dr = 1'b1;
				if (read_fail) begin
					ph_d = msrs_pkg::PH_SET;
				end else if (got) begin
					latch_set = 1'b1;
					cw        = 1'b1;
					cv        = msrs_pkg::CTL_RESET;
					if (wok_s1) ph_d = msrs_pkg::PH_RST_MEAS;
				end
			end
			msrs_pkg::PH_RST_MEAS: begin
				cw   = 1'b1;
				cv   = msrs_pkg::CTL_TMM;
				ph_d = wok_s1 ? msrs_pkg::PH_RST_WAIT : msrs_pkg::PH_SET;
			end
			msrs_pkg::PH_RST_WAIT: begin
				dr = 1'b1;
				if (read_fail) begin
					ph_d = msrs_pkg::PH_SET;
				end else if (got) begin
					sr_pair = 1'b1;
					sv      = 1'b1;
					cw      = 1'b1;
					cv      = msrs_pkg::CTL_TMM;
					ph_d    = wok_s1 ? msrs_pkg::PH_MEASURE : msrs_pkg::PH_SET;
				end
			end
			msrs_pkg::PH_MEASURE: begin
				dr = 1'b1;
				if (read_fail) begin
					ph_d = msrs_pkg::PH_SET;
				end else if (got) begin
					sv = 1'b1;
					if (cnt_q >= limit_q) begin
						// limit reached: recalibrate, no measurement request
						cnt_d = '0;
						ph_d  = msrs_pkg::PH_SET;
					end else begin
						cnt_d = cnt_q + 1'b1;
						cw    = 1'b1;
						cv    = msrs_pkg::CTL_TMM;
						if (!wok_s1) ph_d = msrs_pkg::PH_SET;
					end
				end
			end
			default: begin
				cw   = 1'b1;
				cv   = msrs_pkg::CTL_SET;
				ph_d = wok_s1 ? msrs_pkg::PH_SET_MEAS : msrs_pkg::PH_SET;
			end
		endcase
	end

	// sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= msrs_pkg::PH_SET;
			cnt_q <= '0;
		end else if (fire) begin
			ph_q  <= ph_d;
			cnt_q <= cnt_d;
		end
	end

	// axis datapaths
	assign axis_ctl.latch_set = fire && latch_set;
	assign axis_ctl.sr_pair   = fire && sr_pair;

	msrs_axis #(.COUNT_BITS(COUNT_BITS)) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (axis_ctl),
		.raw    (raw_x_s1),
		.field  (fx)
	);

	msrs_axis #(.COUNT_BITS(COUNT_BITS)) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (axis_ctl),
		.raw    (raw_y_s1),
		.field  (fy)
	);

	msrs_axis #(.COUNT_BITS(COUNT_BITS)) u_axis_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (axis_ctl),
		.raw    (raw_z_s1),
		.field  (fz)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= v_s1;
		end
	end

	// result register payload, fields zero unless a sample is produced
	always_ff @(posedge clk) begin
		if (fire) begin
			cw_q <= cw;
			cv_q <= cv;
			dr_q <= dr;
			sv_q <= sv;
			fx_q <= sv ? fx : '0;
			fy_q <= sv ? fy : '0;
			fz_q <= sv ? fz : '0;
		end
	end

	// result channel
	assign out_ch.valid         = out_v_q;
	assign out_ch.control_write = cw_q;
	assign out_ch.control_value = cv_q;
	assign out_ch.data_read     = dr_q;
	assign out_ch.sample_valid  = sv_q;
	assign out_ch.field_x       = fx_q;
	assign out_ch.field_y       = fy_q;
	assign out_ch.field_z       = fz_q;

endmodule
